[sv/sfe_pkg.sv]
package sfe_pkg;

  // Line codes
  localparam logic [7:0] SlipEnd    = 8'o300;
  localparam logic [7:0] SlipEsc    = 8'o333;
  localparam logic [7:0] SlipEscEnd = 8'o334;
  localparam logic [7:0] SlipEscEsc = 8'o335;
  localparam logic [7:0] ChCr       = 8'h0D;
  localparam logic [7:0] ChLf       = 8'h0A;

  // Request actions
  localparam logic [1:0] ActPacket = 2'd0;
  localparam logic [1:0] ActDebug  = 2'd1;
  localparam logic [1:0] ActTick   = 2'd2;

  // Register indexes
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CfgFragSize  = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgFragDelay = 4'd1;

  // Register reset values
  localparam logic [15:0] FragSizeRst  = 16'd62;
  localparam logic [15:0] FragDelayRst = 16'd1000;
  localparam logic [6:0]  ReloadRst    = 7'd2;

  // Reciprocal of 1000 scaled by 2**26, exact for 16-bit dividends
  localparam logic [16:0] RecipK = 17'd67109;
  localparam int unsigned RecipShift = 26;

  localparam int unsigned MaxBytes = 4;

  typedef struct packed {
    logic [15:0] frag_size;
    logic [15:0] frag_delay;
    logic [6:0]  reload;
  } cfg_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               cnt;
    logic                     tick;
  } item_t;

  // Expand one request into the line bytes it causes
  function automatic item_t expand(logic [1:0] act, logic [7:0] c, logic last,
                                   logic dbg);
    item_t it;
    logic [2:0] n;
    it = '0;
    n = 3'd0;
    it.tick = (act == ActTick);
    case (act)
      ActPacket: begin
        if (dbg) begin
          it.bytes[n[1:0]] = SlipEnd;
          n = n + 3'd1;
        end
        if (c == SlipEnd) begin
          it.bytes[n[1:0]] = SlipEsc;
          n = n + 3'd1;
          it.bytes[n[1:0]] = SlipEscEnd;
          n = n + 3'd1;
        end else if (c == SlipEsc) begin
          it.bytes[n[1:0]] = SlipEsc;
          n = n + 3'd1;
          it.bytes[n[1:0]] = SlipEscEsc;
          n = n + 3'd1;
        end else begin
          it.bytes[n[1:0]] = c;
          n = n + 3'd1;
        end
        if (last) begin
          it.bytes[n[1:0]] = SlipEnd;
          n = n + 3'd1;
        end
      end
      ActDebug: begin
        if (!dbg) begin
          it.bytes[n[1:0]] = SlipEnd;
          n = n + 3'd1;
          it.bytes[n[1:0]] = ChCr;
          n = n + 3'd1;
        end
        it.bytes[n[1:0]] = c;
        n = n + 3'd1;
        if (c == ChLf) begin
          it.bytes[n[1:0]] = SlipEnd;
          n = n + 3'd1;
        end
      end
      default: begin
        n = 3'd0;
      end
    endcase
    it.cnt = n;
    return it;
  endfunction

endpackage

[sv/sfe_if.sv]
interface sfe_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, action, data_byte, last_byte, input ready);
  modport sink (input valid, action, data_byte, last_byte, output ready);
endinterface

interface sfe_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       pause_after;
  logic       run_end;

  modport source (output valid, line_byte, pause_after, run_end, input ready);
  modport sink (input valid, line_byte, pause_after, run_end, output ready);
endinterface

interface sfe_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/sfe_cfg.sv]
module sfe_cfg
  import sfe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  sfe_cfg_if.sink   cfg_i,
  output cfg_t      cfg_o
);

  logic [15:0] frag_size_q;
  logic [15:0] frag_delay_q;
  logic [6:0]  reload_q;
  logic [6:0]  reload_d;
  logic [32:0] recip_prod;
  logic        wr;

  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid;

  // Idle reload = delay / 1000 + 1, by reciprocal multiply
  assign recip_prod = {17'd0, cfg_i.data} * {16'd0, RecipK};
  assign reload_d   = recip_prod[RecipShift +: 7] + 7'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frag_size_q  <= FragSizeRst;
      frag_delay_q <= FragDelayRst;
      reload_q     <= ReloadRst;
    end else if (wr) begin
      case (cfg_i.index)
        CfgFragSize: begin
          frag_size_q <= cfg_i.data;
        end
        CfgFragDelay: begin
          frag_delay_q <= cfg_i.data;
          reload_q     <= reload_d;
        end
        default: begin
          frag_size_q <= frag_size_q;
        end
      endcase
    end
  end

  assign cfg_o.frag_size  = frag_size_q;
  assign cfg_o.frag_delay = frag_delay_q;
  assign cfg_o.reload     = reload_q;

endmodule

[sv/sfe_expander.sv]
module sfe_expander
  import sfe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  sfe_item_if.sink items_i,
  input  logic     take_i,
  output logic     item_valid_o,
  output item_t    item_o
);

  logic  valid_q;
  logic  dbg_q;
  logic  dbg_d;
  logic  accept;
  item_t item_q;

  // Accept when the register is empty or drains this cycle
  assign items_i.ready = !valid_q || take_i;
  assign accept = items_i.valid && items_i.ready;

  // Track whether a debug line is open
  always_comb begin
    case (items_i.action)
      ActPacket: dbg_d = 1'b0;
      ActDebug:  dbg_d = (items_i.data_byte != ChLf);
      default:   dbg_d = dbg_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dbg_q   <= 1'b0;
    end else begin
      if (accept) begin
        valid_q <= 1'b1;
        dbg_q   <= dbg_d;
      end else if (take_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Hold the expanded request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= expand(items_i.action, items_i.data_byte, items_i.last_byte, dbg_q);
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

`ifndef ASSERT_OFF
  a_item_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !take_i |=> $stable(item_q))
    else $error("expanded request changed while waiting");
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> valid_q)
    else $error("request taken from an empty register");
`endif

endmodule

[sv/sfe_pacer.sv]
module sfe_pacer
  import sfe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         item_valid_i,
  input  item_t        item_i,
  output logic         take_o,
  sfe_result_if.source results_o
);

  logic [1:0]  pos_q, pos_d;
  logic [15:0] burst_q, burst_d;
  logic [6:0]  idle_q, idle_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q;
  logic        pause_q, pause_d;
  logic        end_q, end_d;
  logic        out_free;
  logic        emit;
  logic        last_pos;
  logic [15:0] cnt0, cnt1;

  assign out_free = !out_valid_q || results_o.ready;
  assign emit     = item_valid_i && (item_i.cnt != 3'd0) && out_free;
  assign last_pos = ({1'b0, pos_q} == item_i.cnt - 3'd1);

  // Advance the burst count for the byte going out
  always_comb begin
    cnt0 = ((cfg_i.frag_delay == 16'd0) || (idle_q == 7'd0)) ? 16'd0 : burst_q;
    cnt1 = (cnt0 == 16'hFFFF) ? cnt0 : cnt0 + 16'd1;
  end

  always_comb begin
    pos_d       = pos_q;
    burst_d     = burst_q;
    idle_d      = idle_q;
    out_valid_d = out_valid_q && !results_o.ready;
    pause_d     = 1'b0;
    end_d       = 1'b0;
    take_o      = 1'b0;
    if (item_valid_i && item_i.cnt == 3'd0) begin
      // Consume a request with no bytes; a tick counts the idle timer down
      take_o = 1'b1;
      if (item_i.tick && idle_q != 7'd0) begin
        idle_d = idle_q - 7'd1;
      end
    end else if (emit) begin
      out_valid_d = 1'b1;
      if (cfg_i.frag_size != 16'd0 && cnt1 >= cfg_i.frag_size) begin
        burst_d = 16'd0;
        pause_d = 1'b1;
      end else begin
        burst_d = cnt1;
      end
      if (cfg_i.frag_delay != 16'd0) begin
        idle_d = cfg_i.reload;
      end
      end_d = last_pos;
      if (last_pos) begin
        take_o = 1'b1;
        pos_d  = 2'd0;
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 2'd0;
      burst_q     <= 16'd0;
      idle_q      <= 7'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      burst_q     <= burst_d;
      idle_q      <= idle_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q  <= item_i.bytes[pos_q];
      pause_q <= pause_d;
      end_q   <= end_d;
    end
  end

  assign results_o.valid       = out_valid_q;
  assign results_o.line_byte   = byte_q;
  assign results_o.pause_after = pause_q;
  assign results_o.run_end     = end_q;

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && item_i.cnt != 3'd0 |-> {1'b0, pos_q} < item_i.cnt)
    else $error("byte position beyond expanded request");
  a_pause_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && pause_q |-> cfg_i.frag_size != 16'd0)
    else $error("pause marked with pausing disabled");
  a_tick_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && item_i.cnt == 3'd0 && item_i.tick && idle_q != 7'd0
      |=> idle_q == $past(idle_q) - 7'd1)
    else $error("tick did not count the idle timer down");
`endif

endmodule

[sv/slip_frame_encoder_paced.sv]
// Paced SLIP framing transmitter. Each request is a packet byte, a debug
// character or a timer tick; it is expanded into up to four line bytes
// (SLIP escapes, END framing, debug line open/close) and the bytes leave
// one per cycle unless the result port stalls, via a byte-wide result
// register, each tagged with a pause marker from the burst counter. A
// request is held until its one to four line bytes have left; ticks and
// ignored actions produce nothing; the byte-wide port sets this rate. The
// first byte passes the expander's request register, then the result
// register. Registers: index 0 fragment_size, index 1 fragment_delay_us;
// write them only while the block is idle. Other indexes are ignored.
module slip_frame_encoder_paced
  import sfe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  sfe_item_if.sink     items_i,
  sfe_result_if.source results_o,
  sfe_cfg_if.sink      cfg_i
);

  cfg_t  cfg;
  logic  item_valid;
  item_t item;
  logic  take;

  sfe_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  sfe_expander u_expander (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .items_i      (items_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  sfe_pacer u_pacer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .results_o    (results_o)
  );

endmodule
